/* sv/b2da_pkg.sv */
// Shared constants and types for the binary to decimal ASCII converter.
package b2da_pkg;

  // Width of the input field and of the value actually converted.
  localparam int unsigned NUMBER_W    = 32;
  localparam int unsigned NUMBER_BITS = 32;
  localparam int unsigned EXT_W       = (NUMBER_BITS > NUMBER_W) ? NUMBER_BITS : NUMBER_W;

  // Enough decimal digits for the largest NUMBER_BITS-bit value.
  localparam int unsigned NUM_DIGITS  = (NUMBER_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W   = $clog2(NUMBER_BITS + 1);
  localparam int unsigned DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned ASCII_ZERO  = 48;

  typedef logic [NUMBER_W-1:0] number_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [3:0]          digit_t;

  // Requests from the sequencer to the conversion datapath.
  typedef struct packed {
    logic load;
    logic digit_shift;
  } dab_cmd_t;

  // Status from the conversion datapath.
  typedef struct packed {
    logic   done;
    digit_t top_digit;
  } dab_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

endpackage

/* sv/b2da_if.sv */
// Handshake channel interfaces for numbers in and digit characters out.
interface b2da_num_if;
  logic                              valid;
  logic                              ready;
  logic [b2da_pkg::NUMBER_W-1:0]     number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface b2da_chr_if;
  logic                              valid;
  logic                              ready;
  logic [b2da_pkg::CHAR_W-1:0]       digit_char;
  logic                              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

/* sv/b2da_dabble.sv */
// Bit-serial double-dabble converter with a digit-wide shift-out path.
module b2da_dabble (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b2da_pkg::dab_cmd_t        cmd_i,
  input  logic [b2da_pkg::NUMBER_W-1:0] number_i,
  output b2da_pkg::dab_sts_t        sts_o
);
  import b2da_pkg::*;

  logic [NUMBER_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   conv_q, conv_d;
  logic [EXT_W-1:0]       num_ext;

  assign num_ext = EXT_W'(number_i);

  // Add three to every digit of five or more before the next doubling.
  always_comb begin
    digit_t d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd_q[4*i +: 4];
      if (d inside {[4'd5:4'd9]}) begin
        bcd_adj[4*i +: 4] = d + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = d;
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    conv_d = conv_q;
    if (cmd_i.load) begin
      bin_d  = num_ext[NUMBER_BITS-1:0];
      bcd_d  = '0;
      cnt_d  = BIT_CNT_W'(NUMBER_BITS);
      conv_d = 1'b1;
    end else if (conv_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[NUMBER_BITS-1]};
      bin_d = {bin_q[NUMBER_BITS-2:0], 1'b0};
      cnt_d = cnt_q - BIT_CNT_W'(1);
      if (cnt_q == BIT_CNT_W'(1)) begin
        conv_d = 1'b0;
      end
    end else if (cmd_i.digit_shift) begin
      bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      conv_q <= conv_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign sts_o.done      = conv_q && (cnt_q == BIT_CNT_W'(1));
  assign sts_o.top_digit = bcd_q[BCD_W-1 -: 4];

endmodule

/* sv/binary_to_decimal_ascii_unit.sv */
// Top level: converts an unsigned number to a run of ASCII decimal digits.
//
//   channel  dir  payload                    role
//   num_i    in   number[31:0]               value to print
//   chr_o    out  digit_char[5:0], last_digit one character, MSD first
//
// A number is loaded, run through the bit-serial double-dabble loop, then
// has its leading zeros dropped one at a time, takes a step to reach the
// digits and sends them one by one; dropped zeros and sent digits always
// add up to NUM_DIGITS.
// The next number is taken once the last digit sits in the output register.
// A stalled output holds the character and pauses the digit sequencer; reset
// clears the sequencer and the output valid, and there is no clearing pass.
module binary_to_decimal_ascii_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  b2da_num_if.sink    num_i,
  b2da_chr_if.source  chr_o
);
  import b2da_pkg::*;

  state_e               state_q, state_d;
  logic [DIG_CNT_W-1:0] dig_cnt_q, dig_cnt_d;
  logic                 out_valid_q, out_valid_d;
  char_t                out_char_q, out_char_d;
  logic                 out_last_q, out_last_d;
  logic                 out_free;
  dab_cmd_t             cmd;
  dab_sts_t             sts;

  b2da_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .number_i (num_i.number),
    .sts_o    (sts)
  );

  assign num_i.ready = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || chr_o.ready;

  always_comb begin
    state_d         = state_q;
    dig_cnt_d       = dig_cnt_q;
    out_valid_d     = out_valid_q && !chr_o.ready;
    out_char_d      = out_char_q;
    out_last_d      = out_last_q;
    cmd.load        = 1'b0;
    cmd.digit_shift = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (num_i.valid) begin
          cmd.load = 1'b1;
          state_d  = ST_CONV;
        end
      end
      ST_CONV: begin
        dig_cnt_d = DIG_CNT_W'(NUM_DIGITS);
        if (sts.done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros but always keep the last digit.
        if (sts.top_digit == 4'd0 && dig_cnt_q != DIG_CNT_W'(1)) begin
          cmd.digit_shift = 1'b1;
          dig_cnt_d       = dig_cnt_q - DIG_CNT_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_char_d      = char_t'(ASCII_ZERO) + char_t'(sts.top_digit);
          out_last_d      = (dig_cnt_q == DIG_CNT_W'(1));
          cmd.digit_shift = 1'b1;
          dig_cnt_d       = dig_cnt_q - DIG_CNT_W'(1);
          if (dig_cnt_q == DIG_CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dig_cnt_q   <= dig_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign chr_o.valid      = out_valid_q;
  assign chr_o.digit_char = out_char_q;
  assign chr_o.last_digit = out_last_q;

endmodule
